/* hw/rtl/sida_pkg.sv */
// Shared constants and helper functions for the signed decimal text converter.
package sida_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int CHAR_WIDTH   = 6;
   localparam int DIGIT_WIDTH  = 4;
   // Double-dabble steps done in one pipeline stage.
   localparam int STEP_BITS    = 8;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_LIMIT  = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_OFFSET = 4'd3;

   // Decimal digits needed for the largest magnitude, 2**(w-1).
   function automatic int digit_count(input int w);
      logic [64:0] v;
      int n;
      v = 65'd1 << (w - 1);
      n = 0;
      for (int i = 0; i < 25; i++) begin
         if (v != 65'd0) begin
            v = v / 10;
            n = n + 1;
         end
      end
      return n;
   endfunction

   function automatic int pos_width(input int digits);
      return (digits > 1) ? $clog2(digits) : 1;
   endfunction

endpackage

/* hw/rtl/sida_ifs.sv */
// Stream interfaces for the number input and the character output.
interface sida_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [sida_pkg::NUMBER_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface sida_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sida_pkg::CHAR_WIDTH-1:0] text_char;
   logic                            last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

/* hw/rtl/sida_sign.sv */
// Input stage: take the sign and the magnitude of the incoming value.
module sida_sign #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [sida_pkg::NUMBER_WIDTH-1:0] in_number,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [VALUE_WIDTH-1:0]                  out_mag,
   output logic                                    out_neg
);

   logic signed [VALUE_WIDTH-1:0] value;
   logic [VALUE_WIDTH-1:0]        mag_in;
   logic [VALUE_WIDTH-1:0]        mag_ff;
   logic                          neg_in;
   logic                          neg_ff;
   logic                          valid_ff;
   logic                          advance;

   generate
      if (VALUE_WIDTH >= sida_pkg::NUMBER_WIDTH) begin : g_extend
         assign value = VALUE_WIDTH'(in_number);
      end else begin : g_truncate
         assign value = in_number[VALUE_WIDTH-1:0];
      end
   endgenerate

   // The most negative value negates onto itself, which reads right as unsigned.
   assign neg_in = value[VALUE_WIDTH-1];
   assign mag_in = neg_in ? (~value + 1'b1) : value;

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

endmodule

/* hw/rtl/sida_dabble.sv */
// One double-dabble stage: shift STEP_BITS magnitude bits into the BCD digits.
module sida_dabble #(
   parameter int DIGITS = 10,
   parameter int BIN_W  = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [DIGITS*sida_pkg::DIGIT_WIDTH-1:0]    in_bcd,
   input  logic [BIN_W-1:0]                           in_bin,
   input  logic                                       in_neg,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [DIGITS*sida_pkg::DIGIT_WIDTH-1:0]    out_bcd,
   output logic [BIN_W-1:0]                           out_bin,
   output logic                                       out_neg
);

   localparam int DW    = sida_pkg::DIGIT_WIDTH;
   localparam int BCD_W = DIGITS * DW;

   logic [BCD_W+BIN_W-1:0] acc;
   logic [BCD_W-1:0]       bcd_ff;
   logic [BIN_W-1:0]       bin_ff;
   logic                   neg_ff;
   logic                   valid_ff;
   logic                   advance;

   always_comb begin
      acc = {in_bcd, in_bin};
      for (int s = 0; s < sida_pkg::STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (acc[BIN_W + d*DW +: DW] >= sida_pkg::DABBLE_LIMIT) begin
               acc[BIN_W + d*DW +: DW] = acc[BIN_W + d*DW +: DW] + sida_pkg::DABBLE_OFFSET;
            end
         end
         acc = acc << 1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_bcd   = bcd_ff;
   assign out_bin   = bin_ff;
   assign out_neg   = neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bcd_ff <= acc[BIN_W +: BCD_W];
         bin_ff <= acc[BIN_W-1:0];
         neg_ff <= in_neg;
      end
   end

endmodule

/* hw/rtl/sida_serial.sv */
// Serializer: emit sign and significant digits one character per transaction.
module sida_serial #(
   parameter int DIGITS = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [DIGITS*sida_pkg::DIGIT_WIDTH-1:0] in_bcd,
   input  logic                                    in_neg,
   sida_rsp_if.source                              rsp_if
);

   localparam int DW    = sida_pkg::DIGIT_WIDTH;
   localparam int BCD_W = DIGITS * DW;
   localparam int POS_W = sida_pkg::pos_width(DIGITS);

   logic [BCD_W-1:0]                bcd_ff;
   logic [POS_W-1:0]                pos_ff;
   logic [POS_W-1:0]                lead;
   logic                            busy_ff;
   logic                            sign_ff;
   logic                            emit;
   logic                            finish;
   logic                            load;
   logic [DW-1:0]                   digit;
   logic [sida_pkg::CHAR_WIDTH-1:0] char_in;
   logic                            last_in;
   logic [sida_pkg::CHAR_WIDTH-1:0] char_ff;
   logic                            last_ff;
   logic                            out_valid_ff;

   // Highest nonzero digit; zero maps to the ones digit.
   always_comb begin
      lead = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[i*DW +: DW] != '0) begin
            lead = POS_W'(i);
         end
      end
   end

   assign digit  = bcd_ff[pos_ff*DW +: DW];
   assign emit   = busy_ff && (!out_valid_ff || rsp_if.ready);
   assign finish = emit && !sign_ff && (pos_ff == '0);
   assign in_ready = !busy_ff || finish;
   assign load   = in_valid && in_ready;

   always_comb begin
      if (sign_ff) begin
         char_in = sida_pkg::CHAR_MINUS;
         last_in = 1'b0;
      end else begin
         char_in = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_WIDTH'(digit);
         last_in = (pos_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff  <= in_bcd;
         pos_ff  <= lead;
         sign_ff <= in_neg;
      end else if (emit) begin
         if (sign_ff) begin
            sign_ff <= 1'b0;
         end else begin
            pos_ff <= pos_ff - 1'b1;
         end
      end
      if (emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.text_char = char_ff;
   assign rsp_if.last_char = last_ff;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii_top.sv */
// From taking a number to the earliest taking of its first character, the data passes
// one sign stage, one double-dabble stage per 8 bits, the serializer load and the output
// register.
// Throughput: one character per cycle on the response side while rsp_if.ready is held;
// a number has 1 to 11 characters at 32 bits; the character serializer sets the rate.
// Reset: synchronous, clears every valid bit and the serializer's busy flag; no other state.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sida_req_if.sink   req_if,
   sida_rsp_if.source rsp_if
);

   localparam int DIGITS = sida_pkg::digit_count(VALUE_WIDTH);
   localparam int BCD_W  = DIGITS * sida_pkg::DIGIT_WIDTH;
   localparam int NSTG   = (VALUE_WIDTH + sida_pkg::STEP_BITS - 1) / sida_pkg::STEP_BITS;
   localparam int PAD_W  = NSTG * sida_pkg::STEP_BITS;

   logic [VALUE_WIDTH-1:0] sign_mag;
   logic [BCD_W-1:0]       bcd_st   [NSTG+1];
   logic [PAD_W-1:0]       bin_st   [NSTG+1];
   logic                   neg_st   [NSTG+1];
   logic                   valid_st [NSTG+1];
   logic                   ready_st [NSTG+1];

   sida_sign #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_sign (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_number (req_if.number),
      .out_valid (valid_st[0]),
      .out_ready (ready_st[0]),
      .out_mag   (sign_mag),
      .out_neg   (neg_st[0])
   );

   assign bcd_st[0] = '0;
   assign bin_st[0] = PAD_W'(sign_mag);

   generate
      for (genvar g = 0; g < NSTG; g++) begin : g_dabble
         sida_dabble #(
            .DIGITS (DIGITS),
            .BIN_W  (PAD_W)
         ) u_dabble (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_st[g]),
            .in_ready  (ready_st[g]),
            .in_bcd    (bcd_st[g]),
            .in_bin    (bin_st[g]),
            .in_neg    (neg_st[g]),
            .out_valid (valid_st[g+1]),
            .out_ready (ready_st[g+1]),
            .out_bcd   (bcd_st[g+1]),
            .out_bin   (bin_st[g+1]),
            .out_neg   (neg_st[g+1])
         );
      end
   endgenerate

   sida_serial #(
      .DIGITS (DIGITS)
   ) u_serial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_st[NSTG]),
      .in_ready (ready_st[NSTG]),
      .in_bcd   (bcd_st[NSTG]),
      .in_neg   (neg_st[NSTG]),
      .rsp_if   (rsp_if)
   );

endmodule
